// File: hdl/lifr_pkg.sv
package lifr_pkg;

  localparam int MAX_FRAMES   = 4096;
  localparam int SAMPLE_BITS  = 24;
  localparam int FRAC_BITS    = 16;
  localparam int ADDR_BITS    = $clog2(MAX_FRAMES);

  localparam int FRAMES_W     = 13;
  localparam int CHAN_W       = 2;
  localparam int NEW_FRAMES_W = 16;
  localparam int POS_W        = 28;
  localparam int OP_W         = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 28;

  localparam int PROD_W       = NEW_FRAMES_W + POS_W;
  localparam int INT_W        = PROD_W - FRAC_BITS;
  localparam int POS_INT_W    = POS_W - FRAC_BITS;
  localparam int DIFF_W       = SAMPLE_BITS + 1;
  localparam int MUL_W        = DIFF_W + FRAC_BITS + 1;
  localparam int FRAME_BITS   = 2 * SAMPLE_BITS;
  localparam int FIFO_DEPTH   = 4;

  localparam logic [FRAMES_W-1:0]     OLD_FRAMES_RST   = FRAMES_W'(4096);
  localparam logic [CHAN_W-1:0]       OLD_CHANNELS_RST = CHAN_W'(2);
  localparam logic [NEW_FRAMES_W-1:0] NEW_FRAMES_RST   = NEW_FRAMES_W'(4096);
  localparam logic [CHAN_W-1:0]       NEW_CHANNELS_RST = CHAN_W'(2);
  localparam logic [POS_W-1:0]        STEP_RST         = POS_W'(65536);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD     = 2'd0,
    OP_RESAMPLE = 2'd1,
    OP_READ     = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OLD_FRAMES   = 3'd0,
    REG_OLD_CHANNELS = 3'd1,
    REG_NEW_FRAMES   = 3'd2,
    REG_NEW_CHANNELS = 3'd3,
    REG_STEP         = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    JOB_WRITE = 1'b0,
    JOB_READ  = 1'b1
  } kind_e;

  // How the two interpolation lanes map onto the output ports.
  typedef enum logic [1:0] {
    OUT_SINGLE = 2'd0,
    OUT_DUAL   = 2'd1,
    OUT_COPY   = 2'd2,
    OUT_MIX    = 2'd3
  } mode_e;

  typedef struct packed {
    logic [FRAMES_W-1:0]     old_frames;
    logic [CHAN_W-1:0]       old_channels;
    logic [NEW_FRAMES_W-1:0] new_frames;
    logic [CHAN_W-1:0]       new_channels;
    logic [POS_W-1:0]        step;
  } cfg_t;

  typedef struct packed {
    kind_e                 kind;
    logic [ADDR_BITS-1:0]  addr;
    logic [FRAC_BITS-1:0]  frac;
    logic                  err;
    logic                  use_y1;
    logic                  chan_a;
    mode_e                 mode;
    sample_t               left;
    sample_t               right;
  } job_t;

endpackage

// File: hdl/lifr_ram.sv
module lifr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: hdl/lifr_front.sv
module lifr_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lifr_pkg::cfg_t                        cfg_i,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [lifr_pkg::OP_W-1:0]             op_i,
  input  logic [lifr_pkg::NEW_FRAMES_W-1:0]     frame_index_i,
  input  logic [lifr_pkg::POS_W-1:0]            position_q16_i,
  input  logic                                  read_channel_i,
  input  lifr_pkg::sample_t                     sample_left_i,
  input  lifr_pkg::sample_t                     sample_right_i,
  input  logic                                  full_i,
  output logic                                  push_o,
  output lifr_pkg::job_t                        job_o
);

  logic                                  valid_q, valid_d;
  logic [lifr_pkg::OP_W-1:0]             op_q;
  logic [lifr_pkg::NEW_FRAMES_W-1:0]     fidx_q;
  logic [lifr_pkg::POS_W-1:0]            pos_q;
  logic                                  rch_q;
  lifr_pkg::sample_t                     left_q, right_q;
  logic [lifr_pkg::PROD_W-1:0]           prod_q, prod_d;

  logic                                  accept;
  logic                                  need_push;
  logic                                  advance;
  logic [lifr_pkg::FRAMES_W-1:0]         nf;
  logic                                  src_stereo, dst_stereo;
  logic [lifr_pkg::INT_W-1:0]            idx1;
  logic [lifr_pkg::FRAC_BITS-1:0]        frac1, frac2;
  logic [lifr_pkg::POS_INT_W-1:0]        idx2;
  logic                                  err1, err2, last1;

  assign accept = start_i && !busy_o;
  assign prod_d = frame_index_i * cfg_i.step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      fidx_q  <= frame_index_i;
      pos_q   <= position_q16_i;
      rch_q   <= read_channel_i;
      left_q  <= sample_left_i;
      right_q <= sample_right_i;
      prod_q  <= prod_d;
    end
  end

  assign nf = (cfg_i.old_frames > lifr_pkg::FRAMES_W'(lifr_pkg::MAX_FRAMES)) ?
              lifr_pkg::FRAMES_W'(lifr_pkg::MAX_FRAMES) : cfg_i.old_frames;
  assign src_stereo = cfg_i.old_channels >= lifr_pkg::CHAN_W'(2);
  assign dst_stereo = cfg_i.new_channels >= lifr_pkg::CHAN_W'(2);

  assign idx1  = prod_q[lifr_pkg::PROD_W-1:lifr_pkg::FRAC_BITS];
  assign frac1 = prod_q[lifr_pkg::FRAC_BITS-1:0];
  assign err1  = (fidx_q >= cfg_i.new_frames) || (idx1 >= lifr_pkg::INT_W'(nf));
  assign last1 = ({1'b0, idx1} + (lifr_pkg::INT_W+1)'(1)) == (lifr_pkg::INT_W+1)'(nf);

  assign idx2  = pos_q[lifr_pkg::POS_W-1:lifr_pkg::FRAC_BITS];
  assign frac2 = pos_q[lifr_pkg::FRAC_BITS-1:0];
  assign err2  = (lifr_pkg::FRAMES_W'(idx2) >= nf) ||
                 (((lifr_pkg::FRAMES_W'(idx2) + lifr_pkg::FRAMES_W'(1)) == nf) &&
                  (frac2 != '0)) ||
                 (rch_q && !src_stereo);

  always_comb begin
    need_push    = 1'b0;
    job_o.kind   = lifr_pkg::JOB_READ;
    job_o.addr   = idx2[lifr_pkg::ADDR_BITS-1:0];
    job_o.frac   = frac2;
    job_o.err    = err2;
    job_o.use_y1 = (frac2 == '0);
    job_o.chan_a = rch_q;
    job_o.mode   = lifr_pkg::OUT_SINGLE;
    job_o.left   = left_q;
    job_o.right  = right_q;
    case (lifr_pkg::op_e'(op_q))
      lifr_pkg::OP_LOAD: begin
        // Slots beyond the store are dropped here and never reach the back.
        need_push  = {1'b0, fidx_q} <
                     (lifr_pkg::NEW_FRAMES_W+1)'(lifr_pkg::MAX_FRAMES);
        job_o.kind = lifr_pkg::JOB_WRITE;
        job_o.addr = fidx_q[lifr_pkg::ADDR_BITS-1:0];
      end
      lifr_pkg::OP_RESAMPLE: begin
        need_push    = 1'b1;
        job_o.addr   = idx1[lifr_pkg::ADDR_BITS-1:0];
        job_o.frac   = frac1;
        job_o.err    = err1;
        job_o.use_y1 = last1 || (frac1 == '0);
        job_o.chan_a = 1'b0;
        if (src_stereo) begin
          job_o.mode = dst_stereo ? lifr_pkg::OUT_DUAL : lifr_pkg::OUT_MIX;
        end else begin
          job_o.mode = dst_stereo ? lifr_pkg::OUT_COPY : lifr_pkg::OUT_SINGLE;
        end
      end
      lifr_pkg::OP_READ: begin
        need_push = 1'b1;
      end
      default: begin
        need_push = 1'b0;
      end
    endcase
  end

  assign advance = !valid_q || !need_push || !full_i;
  assign busy_o  = !advance;
  assign push_o  = valid_q && need_push && !full_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance) begin
      valid_d = 1'b0;
    end
  end

endmodule

// File: hdl/lifr_fifo.sv
module lifr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lifr_pkg::job_t data_i,
  input  logic           pop_i,
  output lifr_pkg::job_t data_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int PTR_W = $clog2(lifr_pkg::FIFO_DEPTH);

  lifr_pkg::job_t    mem_q [lifr_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]    cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PTR_W+1)'(lifr_pkg::FIFO_DEPTH));
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + PTR_W'(1) : wr_q;
    rd_d  = pop_i ? rd_q + PTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (PTR_W+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job queue read while empty");

endmodule

// File: hdl/lifr_back.sv
module lifr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  lifr_pkg::job_t    job_i,
  output logic              result_valid_o,
  output lifr_pkg::sample_t out_left_o,
  output lifr_pkg::sample_t out_right_o,
  output logic              range_error_o
);

  localparam int SB = lifr_pkg::SAMPLE_BITS;

  // Stage 1: frame store read data.
  logic                            b1_valid_q;
  logic [lifr_pkg::FRAC_BITS-1:0]  b1_frac_q;
  logic                            b1_err_q, b1_use_y1_q, b1_chan_a_q;
  lifr_pkg::mode_e                 b1_mode_q;
  logic [lifr_pkg::FRAME_BITS-1:0] rd_a, rd_b;

  // Stage 2: lane products.
  logic                            b2_valid_q;
  logic                            b2_err_q, b2_use_y1_q;
  lifr_pkg::mode_e                 b2_mode_q;
  lifr_pkg::sample_t               b2_ya_q, b2_yb_q;
  logic signed [lifr_pkg::MUL_W-1:0] b2_pa_q, b2_pb_q;

  // Output register.
  logic                            out_valid_q;
  lifr_pkg::sample_t               out_left_q, out_right_q;
  logic                            out_err_q;

  logic                            is_write, is_read;
  lifr_pkg::sample_t               ya0, ya1, yb0, yb1;
  logic signed [lifr_pkg::DIFF_W-1:0] diff_a, diff_b;
  logic signed [lifr_pkg::MUL_W-1:0]  pa_d, pb_d, sa, sb;
  logic signed [lifr_pkg::DIFF_W-1:0] va_w, vb_w, mix_w;
  lifr_pkg::sample_t               va, vb;
  lifr_pkg::sample_t               left_d, right_d;

  assign is_write = job_valid_i && (job_i.kind == lifr_pkg::JOB_WRITE);
  assign is_read  = job_valid_i && (job_i.kind == lifr_pkg::JOB_READ);

  lifr_ram #(
    .WIDTH (lifr_pkg::FRAME_BITS),
    .DEPTH (lifr_pkg::MAX_FRAMES)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (is_write),
    .waddr_i   (job_i.addr),
    .wdata_i   ({job_i.right, job_i.left}),
    .raddr_a_i (job_i.addr),
    .raddr_b_i (job_i.addr + lifr_pkg::ADDR_BITS'(1)),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_comb begin
    ya0    = b1_chan_a_q ? rd_a[2*SB-1:SB] : rd_a[SB-1:0];
    ya1    = b1_chan_a_q ? rd_b[2*SB-1:SB] : rd_b[SB-1:0];
    yb0    = rd_a[2*SB-1:SB];
    yb1    = rd_b[2*SB-1:SB];
    diff_a = lifr_pkg::DIFF_W'(ya1) - lifr_pkg::DIFF_W'(ya0);
    diff_b = lifr_pkg::DIFF_W'(yb1) - lifr_pkg::DIFF_W'(yb0);
    pa_d   = $signed({1'b0, b1_frac_q}) * diff_a;
    pb_d   = $signed({1'b0, b1_frac_q}) * diff_b;
  end

  // The interpolated value lies between its two samples, so the sum wraps back
  // into range and the low bits are exact.
  always_comb begin
    sa    = b2_pa_q >>> lifr_pkg::FRAC_BITS;
    sb    = b2_pb_q >>> lifr_pkg::FRAC_BITS;
    va_w  = lifr_pkg::DIFF_W'(b2_ya_q) + sa[lifr_pkg::DIFF_W-1:0];
    vb_w  = lifr_pkg::DIFF_W'(b2_yb_q) + sb[lifr_pkg::DIFF_W-1:0];
    va    = b2_use_y1_q ? b2_ya_q : va_w[SB-1:0];
    vb    = b2_use_y1_q ? b2_yb_q : vb_w[SB-1:0];
    mix_w = lifr_pkg::DIFF_W'(va) + lifr_pkg::DIFF_W'(vb);
    left_d  = va;
    right_d = '0;
    case (b2_mode_q)
      lifr_pkg::OUT_SINGLE: right_d = '0;
      lifr_pkg::OUT_DUAL:   right_d = vb;
      lifr_pkg::OUT_COPY:   right_d = va;
      lifr_pkg::OUT_MIX:    left_d  = mix_w[SB:1];
      default:              right_d = '0;
    endcase
    if (b2_err_q) begin
      left_d  = '0;
      right_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b1_valid_q  <= is_read;
      b2_valid_q  <= b1_valid_q;
      out_valid_q <= b2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_frac_q   <= job_i.frac;
    b1_err_q    <= job_i.err;
    b1_use_y1_q <= job_i.use_y1;
    b1_chan_a_q <= job_i.chan_a;
    b1_mode_q   <= job_i.mode;

    b2_err_q    <= b1_err_q;
    b2_use_y1_q <= b1_use_y1_q;
    b2_mode_q   <= b1_mode_q;
    b2_ya_q     <= ya0;
    b2_yb_q     <= yb0;
    b2_pa_q     <= pa_d;
    b2_pb_q     <= pb_d;

    out_left_q  <= left_d;
    out_right_q <= right_d;
    out_err_q   <= b2_err_q;
  end

  assign result_valid_o = out_valid_q;
  assign out_left_o     = out_left_q;
  assign out_right_o    = out_right_q;
  assign range_error_o  = out_err_q;

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_write |=> !b1_valid_q)
    else $error("store write produced a result");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> (out_left_q == '0 && out_right_q == '0))
    else $error("range error result carries nonzero samples");

  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $past(b1_valid_q, 2))
    else $error("result without a matching store read");

endmodule

// File: hdl/linear_interp_frame_resampler_unit.sv
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+----------------------------------------
// command   | in        | start / busy            | op, frame_index, position_q16,
//           |           |                         | read_channel, sample_left, sample_right
// result    | out       | result_valid_o (strobe) | out_left, out_right, range_error
// config    | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One command transfer is taken per cycle while busy is low. Its result strobe follows
// the front register, job queue, registered store read, multiplier and output register.
// Reset restores the configuration defaults and empties the pipeline; the frame store is
// not cleared and holds undefined data until each slot is loaded.
// The result side cannot stall, so the back drains one job per cycle and busy only rises
// if the job queue fills, which the steady drain keeps from happening.
module linear_interp_frame_resampler_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [lifr_pkg::OP_W-1:0]         op_i,
  input  logic [lifr_pkg::NEW_FRAMES_W-1:0] frame_index_i,
  input  logic [lifr_pkg::POS_W-1:0]        position_q16_i,
  input  logic                              read_channel_i,
  input  logic signed [lifr_pkg::SAMPLE_BITS-1:0] sample_left_i,
  input  logic signed [lifr_pkg::SAMPLE_BITS-1:0] sample_right_i,
  output logic                              result_valid_o,
  output logic signed [lifr_pkg::SAMPLE_BITS-1:0] out_left_o,
  output logic signed [lifr_pkg::SAMPLE_BITS-1:0] out_right_o,
  output logic                              range_error_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lifr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lifr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  lifr_pkg::cfg_t cfg_q, cfg_d;
  logic           push, full, empty;
  lifr_pkg::job_t job_in, job_out;

  // Configuration writes are always accepted.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (lifr_pkg::cfg_idx_e'(cfg_index_i))
        lifr_pkg::REG_OLD_FRAMES:
          cfg_d.old_frames = cfg_data_i[lifr_pkg::FRAMES_W-1:0];
        lifr_pkg::REG_OLD_CHANNELS:
          cfg_d.old_channels = cfg_data_i[lifr_pkg::CHAN_W-1:0];
        lifr_pkg::REG_NEW_FRAMES:
          cfg_d.new_frames = cfg_data_i[lifr_pkg::NEW_FRAMES_W-1:0];
        lifr_pkg::REG_NEW_CHANNELS:
          cfg_d.new_channels = cfg_data_i[lifr_pkg::CHAN_W-1:0];
        lifr_pkg::REG_STEP:
          cfg_d.step = cfg_data_i[lifr_pkg::POS_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.old_frames   <= lifr_pkg::OLD_FRAMES_RST;
      cfg_q.old_channels <= lifr_pkg::OLD_CHANNELS_RST;
      cfg_q.new_frames   <= lifr_pkg::NEW_FRAMES_RST;
      cfg_q.new_channels <= lifr_pkg::NEW_CHANNELS_RST;
      cfg_q.step         <= lifr_pkg::STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front computes the source position and classifies each command into a
  // store write or a read job; loads to slots past the store and unused op codes
  // are dropped there.
  lifr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .start_i        (start),
    .busy_o         (busy),
    .op_i           (op_i),
    .frame_index_i  (frame_index_i),
    .position_q16_i (position_q16_i),
    .read_channel_i (read_channel_i),
    .sample_left_i  (sample_left_i),
    .sample_right_i (sample_right_i),
    .full_i         (full),
    .push_o         (push),
    .job_o          (job_in)
  );

  lifr_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (!empty),
    .data_o  (job_out),
    .empty_o (empty),
    .full_o  (full)
  );

  // The back applies jobs to the frame store in queue order, so a load is always
  // visible to any read that was accepted after it.
  lifr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (!empty),
    .job_i          (job_out),
    .result_valid_o (result_valid_o),
    .out_left_o     (out_left_o),
    .out_right_o    (out_right_o),
    .range_error_o  (range_error_o)
  );

endmodule
